// ===== src/las_pkg.sv =====
// ----------------------------------------------------------------------------
// las_pkg
// Shared types, codes and scoring helpers of the local alignment scorer.
// ----------------------------------------------------------------------------
package las_pkg;

  localparam int LEN_MAX = 64;
  localparam int IDX_W   = $clog2(LEN_MAX);
  localparam int POS_W   = IDX_W + 1;
  localparam int CNT_W   = 8;
  localparam int SUM_W   = 16;
  localparam int SC_W    = 16;
  localparam int CALC_W  = SC_W + 2;
  localparam int ADDR_W  = 2 * IDX_W;
  localparam int ENTRY_W = 14;

  // commands
  localparam logic [1:0] CMD_LOAD_A = 2'd0;
  localparam logic [1:0] CMD_LOAD_B = 2'd1;
  localparam logic [1:0] CMD_RUN    = 2'd2;

  // traceback codes
  localparam logic [1:0] TR_NONE = 2'd0;
  localparam logic [1:0] TR_DIAG = 2'd1;
  localparam logic [1:0] TR_UP   = 2'd2;
  localparam logic [1:0] TR_LEFT = 2'd3;

  // register indexes
  localparam logic [2:0] REG_WCL  = 3'd0;
  localparam logic [2:0] REG_WCH  = 3'd1;
  localparam logic [2:0] REG_WV   = 3'd2;
  localparam logic [2:0] REG_FAM  = 3'd3;
  localparam logic [2:0] REG_MINN = 3'd4;
  localparam logic [2:0] REG_MINW = 3'd5;
  localparam logic [2:0] REG_EXEC = 3'd6;

  typedef struct packed {
    logic [1:0] command;
    logic [4:0] cap;
    logic [7:0] flags;
    logic       linked;
  } in_word_t;

  typedef struct packed {
    logic       found;
    logic [5:0] a_first;
    logic [5:0] a_last;
    logic [5:0] b_first;
    logic [5:0] b_last;
    logic [7:0] matched;
    logic [7:0] rare;
    logic [7:0] chained;
    logic [7:0] related;
    logic [7:0] mismatch;
    logic [7:0] gap_len;
    logic [7:0] gap_count;
  } out_word_t;

  typedef struct packed {
    logic [47:0] wcl;
    logic [47:0] wch;
    logic [31:0] wv;
    logic [63:0] fam;
    logic [7:0]  min_nodes;
    logic [15:0] min_weight;
    logic [7:0]  exec_mask;
  } cfg_t;

  typedef struct packed {
    logic ld_a;
    logic ld_b;
    logic run_start;
    logic c_issue;
    logic c_eval;
    logic t_start;
    logic t_issue;
    logic t_eval;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic go;
    logic last_cell;
    logic best_zero;
    logic tb_edge;
    logic tb_stop;
  } dp_status_t;

  function automatic logic [7:0] cap_weight(input logic [4:0] cap, input cfg_t cfg);
    logic [2:0] cls;
    logic [7:0] w;
    cls = cap[4] ? cfg.wch[3*cap[3:0] +: 3] : cfg.wcl[3*cap[3:0] +: 3];
    case (cls)
      3'd1:    w = cfg.wv[7:0];
      3'd2:    w = cfg.wv[15:8];
      3'd3:    w = cfg.wv[23:16];
      3'd4:    w = cfg.wv[31:24];
      default: w = 8'd0;
    endcase
    return w;
  endfunction

  function automatic logic [1:0] cap_family(input logic [4:0] cap, input cfg_t cfg);
    return cfg.fam[2*cap +: 2];
  endfunction

  function automatic logic [7:0] sat_inc(input logic [7:0] v);
    return (v == 8'hFF) ? v : v + 8'd1;
  endfunction

endpackage

// ===== src/las_ctrl.sv =====
// ----------------------------------------------------------------------------
// las_ctrl
// Sequencer: loads, matrix fill, traceback and result hand-off.
// ----------------------------------------------------------------------------
module las_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic [1:0]             in_command,
  output logic                   in_stall,
  output logic                   out_valid,
  input  logic                   out_stall,
  input  las_pkg::dp_status_t    status,
  output las_pkg::dp_cmd_t       cmd
);

  typedef enum logic [6:0] {
    IDLE    = 7'b0000001,
    C_ISSUE = 7'b0000010,
    C_EVAL  = 7'b0000100,
    T_INIT  = 7'b0001000,
    T_ISSUE = 7'b0010000,
    T_EVAL  = 7'b0100000,
    FINISH  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   take;

  assign in_stall  = (state_r != IDLE);
  assign out_valid = out_valid_r;
  assign take      = in_valid && (state_r == IDLE);

  // next state and commands
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    unique case (state_r)
      IDLE: begin
        if (take) begin
          if (in_command == las_pkg::CMD_LOAD_A) cmd.ld_a = 1'b1;
          if (in_command == las_pkg::CMD_LOAD_B) cmd.ld_b = 1'b1;
          if (in_command == las_pkg::CMD_RUN) begin
            cmd.run_start = 1'b1;
            state_nxt = status.go ? C_ISSUE : FINISH;
          end
        end
      end
      C_ISSUE: begin
        cmd.c_issue = 1'b1;
        state_nxt = C_EVAL;
      end
      C_EVAL: begin
        cmd.c_eval = 1'b1;
        state_nxt = status.last_cell ? T_INIT : C_ISSUE;
      end
      T_INIT: begin
        if (status.best_zero) begin
          state_nxt = FINISH;
        end else begin
          cmd.t_start = 1'b1;
          state_nxt = T_ISSUE;
        end
      end
      T_ISSUE: begin
        cmd.t_issue = 1'b1;
        state_nxt = status.tb_edge ? FINISH : T_EVAL;
      end
      T_EVAL: begin
        cmd.t_eval = 1'b1;
        state_nxt = status.tb_stop ? FINISH : T_ISSUE;
      end
      FINISH: begin
        if (!(out_valid_r && out_stall)) begin
          cmd.finish = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt = IDLE;
        end
      end
      default: state_nxt = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_fill_follows_issue: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == C_ISSUE |=> state_r == C_EVAL)
    else $error("fill step skipped its read");
  a_finish_raises_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> out_valid_r)
    else $error("result not presented");
  a_no_finish_on_held: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> !(out_valid_r && out_stall))
    else $error("held result overwritten");

endmodule

// ===== src/las_dp.sv =====
// ----------------------------------------------------------------------------
// las_dp
// Sequence stores, score matrix memory, cell arithmetic and traceback counts.
// ----------------------------------------------------------------------------
module las_dp (
  input  logic                   clk,
  input  logic                   rst_n,
  input  las_pkg::in_word_t      in_data,
  input  las_pkg::cfg_t          cfg,
  input  las_pkg::dp_cmd_t       cmd,
  output las_pkg::dp_status_t    status,
  output las_pkg::out_word_t     out_data
);

  localparam int IW = las_pkg::IDX_W;
  localparam int PW = las_pkg::POS_W;
  localparam int CW = las_pkg::CALC_W;
  localparam int SW = las_pkg::SC_W;

  // stores
  logic [las_pkg::ENTRY_W-1:0] seq_a_mem [las_pkg::LEN_MAX];
  logic [las_pkg::ENTRY_W-1:0] seq_b_mem [las_pkg::LEN_MAX];
  logic [SW+1:0]               mat_mem   [2**las_pkg::ADDR_W];
  logic [las_pkg::ENTRY_W-1:0] sa_q, sb_q;
  logic [SW+1:0]               mq;

  logic [las_pkg::CNT_W-1:0] count_a_r, count_b_r;
  logic [las_pkg::SUM_W-1:0] sum_a_r, sum_b_r;
  logic [PW-1:0] na, nb, i_r, j_r, bi_r, bj_r;
  logic [SW-1:0] best_r, diag_r, left_r;
  logic [1:0]    left_tr_r;
  logic          pend_up_r, pend_left_r;
  las_pkg::out_word_t acc_r, out_r, acc_nxt, res_w;

  // load path
  logic [las_pkg::ENTRY_W-1:0] entry;
  logic [7:0]  in_w;
  logic [16:0] sum_a_add, sum_b_add;
  assign entry     = {in_data.linked, in_data.flags, in_data.cap};
  assign in_w      = las_pkg::cap_weight(in_data.cap, cfg);
  assign sum_a_add = {1'b0, sum_a_r} + {9'd0, in_w};
  assign sum_b_add = {1'b0, sum_b_r} + {9'd0, in_w};

  assign na = (count_a_r > 8'(las_pkg::LEN_MAX)) ? PW'(las_pkg::LEN_MAX) : count_a_r[PW-1:0];
  assign nb = (count_b_r > 8'(las_pkg::LEN_MAX)) ? PW'(las_pkg::LEN_MAX) : count_b_r[PW-1:0];

  // memory addressing
  logic [IW-1:0] ra_a, ra_b, prev_row;
  logic [las_pkg::ADDR_W-1:0] m_raddr, m_waddr;
  logic [PW-1:0] i_m2;
  assign ra_a     = 6'(i_r - 7'd1);
  assign ra_b     = 6'(j_r - 7'd1);
  assign i_m2     = i_r - 7'd2;
  assign prev_row = i_m2[IW-1:0];
  assign m_raddr  = cmd.t_issue ? {ra_a, ra_b} : {prev_row, ra_b};
  assign m_waddr  = {ra_a, ra_b};

  // cell arithmetic
  logic [4:0] ca, cb;
  logic [1:0] fa, fb;
  logic       is_match, is_fam;
  logic [7:0] wa;
  logic signed [CW-1:0] diag, up, left, v, s;
  logic [SW-1:0] up_base;
  logic [1:0]    up_tr, t;
  logic          row_first;

  assign ca        = sa_q[4:0];
  assign cb        = sb_q[4:0];
  assign fa        = las_pkg::cap_family(ca, cfg);
  assign fb        = las_pkg::cap_family(cb, cfg);
  assign wa        = las_pkg::cap_weight(ca, cfg);
  assign is_match  = (ca == cb);
  assign is_fam    = !is_match && (fa != 2'd0) && (fa == fb);
  assign row_first = (i_r == 7'd1);
  assign up_base   = row_first ? '0 : mq[SW-1:0];
  assign up_tr     = row_first ? las_pkg::TR_NONE : mq[SW+1:SW];

  always_comb begin
    if (is_match)    s = CW'($signed({1'b0, wa}));
    else if (is_fam) s = CW'(1);
    else             s = CW'(-2);
    diag = $signed({2'b00, diag_r}) + s;
    up   = $signed({2'b00, up_base}) + ((up_tr == las_pkg::TR_UP) ? CW'(-1) : CW'(-3));
    left = $signed({2'b00, left_r}) + ((left_tr_r == las_pkg::TR_LEFT) ? CW'(-1) : CW'(-3));
    v = diag;
    t = las_pkg::TR_DIAG;
    if (up > v) begin
      v = up;
      t = las_pkg::TR_UP;
    end
    if (left > v) begin
      v = left;
      t = las_pkg::TR_LEFT;
    end
    if (v < 0) begin
      v = '0;
      t = las_pkg::TR_NONE;
    end
  end

  // traceback decode
  logic [1:0]    mtr;
  logic [SW-1:0] msc;
  logic          chain;
  assign mtr   = mq[SW+1:SW];
  assign msc   = mq[SW-1:0];
  assign chain = (((sa_q[12:5] & cfg.exec_mask) != 8'd0) &&
                  ((sb_q[12:5] & cfg.exec_mask) != 8'd0)) || (sa_q[13] && sb_q[13]);

  // status
  assign status.go = (count_a_r >= cfg.min_nodes) && (sum_a_r >= cfg.min_weight) &&
                     (count_b_r >= cfg.min_nodes) && (sum_b_r >= cfg.min_weight) &&
                     (na != '0) && (nb != '0);
  assign status.last_cell = (j_r == nb) && (i_r == na);
  assign status.best_zero = (best_r == '0);
  assign status.tb_edge   = (i_r == '0) || (j_r == '0);
  assign status.tb_stop   = (msc == '0) || (mtr == las_pkg::TR_NONE);
  assign out_data         = out_r;

  // next traceback counts
  always_comb begin
    acc_nxt = acc_r;
    if (cmd.t_start) begin
      acc_nxt.a_last = 6'(bi_r - 7'd1);
      acc_nxt.b_last = 6'(bj_r - 7'd1);
    end else if (cmd.t_issue) begin
      // edge cell: its trace is none, so a pending gap opens here
      if (status.tb_edge && (pend_up_r || pend_left_r))
        acc_nxt.gap_count = las_pkg::sat_inc(acc_r.gap_count);
    end else if (cmd.t_eval) begin
      if ((pend_up_r && mtr != las_pkg::TR_UP) || (pend_left_r && mtr != las_pkg::TR_LEFT))
        acc_nxt.gap_count = las_pkg::sat_inc(acc_r.gap_count);
      if (!status.tb_stop) begin
        unique case (mtr)
          las_pkg::TR_DIAG: begin
            if (is_match) begin
              acc_nxt.matched = las_pkg::sat_inc(acc_r.matched);
              if (wa >= cfg.wv[31:24]) acc_nxt.rare = las_pkg::sat_inc(acc_r.rare);
              if (chain) acc_nxt.chained = las_pkg::sat_inc(acc_r.chained);
            end else if (is_fam) begin
              acc_nxt.related = las_pkg::sat_inc(acc_r.related);
            end else begin
              acc_nxt.mismatch = las_pkg::sat_inc(acc_r.mismatch);
            end
            acc_nxt.a_first = ra_a;
            acc_nxt.b_first = ra_b;
          end
          las_pkg::TR_UP:   acc_nxt.gap_len = las_pkg::sat_inc(acc_r.gap_len);
          las_pkg::TR_LEFT: acc_nxt.gap_len = las_pkg::sat_inc(acc_r.gap_len);
          default: ;
        endcase
      end
    end
  end

  // stores and matrix memory
  always_ff @(posedge clk) begin
    if (cmd.ld_a && count_a_r < 8'(las_pkg::LEN_MAX)) seq_a_mem[count_a_r[IW-1:0]] <= entry;
    if (cmd.ld_b && count_b_r < 8'(las_pkg::LEN_MAX)) seq_b_mem[count_b_r[IW-1:0]] <= entry;
    sa_q <= seq_a_mem[ra_a];
    sb_q <= seq_b_mem[ra_b];
  end

  always_ff @(posedge clk) begin
    if (cmd.c_eval) mat_mem[m_waddr] <= {t, v[SW-1:0]};
    mq <= mat_mem[m_raddr];
  end

  // counts and sums
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.finish) begin
      count_a_r <= '0;
      count_b_r <= '0;
      sum_a_r   <= '0;
      sum_b_r   <= '0;
    end else begin
      if (cmd.ld_a) begin
        count_a_r <= las_pkg::sat_inc(count_a_r);
        sum_a_r   <= sum_a_add[16] ? 16'hFFFF : sum_a_add[15:0];
      end
      if (cmd.ld_b) begin
        count_b_r <= las_pkg::sat_inc(count_b_r);
        sum_b_r   <= sum_b_add[16] ? 16'hFFFF : sum_b_add[15:0];
      end
    end
  end

  // fill sweep and traceback walk
  always_ff @(posedge clk) begin
    if (cmd.run_start) begin
      i_r <= 7'd1;
      j_r <= 7'd1;
      best_r <= '0;
      bi_r <= '0;
      bj_r <= '0;
      diag_r <= '0;
      left_r <= '0;
      left_tr_r <= las_pkg::TR_NONE;
      pend_up_r <= 1'b0;
      pend_left_r <= 1'b0;
      acc_r <= '0;
    end else if (cmd.c_eval) begin
      if (v[SW-1:0] > best_r) begin
        best_r <= v[SW-1:0];
        bi_r <= i_r;
        bj_r <= j_r;
      end
      if (j_r == nb) begin
        i_r <= i_r + 7'd1;
        j_r <= 7'd1;
        diag_r <= '0;
        left_r <= '0;
        left_tr_r <= las_pkg::TR_NONE;
      end else begin
        j_r <= j_r + 7'd1;
        diag_r <= up_base;
        left_r <= v[SW-1:0];
        left_tr_r <= t;
      end
    end else if (cmd.t_start) begin
      i_r <= bi_r;
      j_r <= bj_r;
      acc_r <= acc_nxt;
    end else if (cmd.t_issue) begin
      acc_r <= acc_nxt;
    end else if (cmd.t_eval) begin
      acc_r <= acc_nxt;
      pend_up_r <= !status.tb_stop && (mtr == las_pkg::TR_UP);
      pend_left_r <= !status.tb_stop && (mtr == las_pkg::TR_LEFT);
      if (!status.tb_stop) begin
        unique case (mtr)
          las_pkg::TR_DIAG: begin
            i_r <= i_r - 7'd1;
            j_r <= j_r - 7'd1;
          end
          las_pkg::TR_UP:   i_r <= i_r - 7'd1;
          las_pkg::TR_LEFT: j_r <= j_r - 7'd1;
          default: ;
        endcase
      end
    end
  end

  // result register
  always_comb begin
    res_w = acc_r;
    res_w.found = (acc_r.matched != 8'd0);
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) out_r <= res_w;
  end

  a_counts_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> (count_a_r == '0) && (count_b_r == '0))
    else $error("counts not cleared after a run");
  a_best_has_cell: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.t_issue || cmd.t_eval) |-> (best_r != '0) && (bi_r != '0) && (bj_r != '0))
    else $error("traceback without a best cell");
  a_gap_order: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.t_eval |-> acc_r.gap_count <= acc_r.gap_len)
    else $error("more gap openings than gap steps");

endmodule

// ===== src/local_alignment_scorer_unit.sv =====
// ----------------------------------------------------------------------------
// local_alignment_scorer_unit
// Local alignment of two capability sequences with affine gap scoring.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  channel: one word per command. Load words (sequence A or B) are
//         taken one per cycle while idle and give no result. A run word
//         fills the score matrix and traces back the best cell.
//   out_* channel: one result word per run word.
//   cfg_* port: APB-style, 64-bit data, register i at byte address 8*i.
//         Write only while the block is idle.
// A run sweeps the matrix cell by cell: for each cell one read of the previous
//   row from the matrix memory, then one compute and write. A setup step
//   follows, then the traceback steps, each a read and an evaluation; when
//   the walk ends the result is loaded and out_valid is raised. With no
//   positive cell the traceback is skipped; a run that fails the size and
//   weight gate or has an empty sequence goes straight to its result.
// While a run is in progress in_stall stays high. A finished result waits in
//   the output register; a further result waits until it is taken.
// Reset clears the counts, sums, configuration registers and handshake state;
//   the sequence stores and matrix memory need no clearing.
// ----------------------------------------------------------------------------
module local_alignment_scorer_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  las_pkg::in_word_t    in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output las_pkg::out_word_t   out_data,
  input  logic                 cfg_psel,
  input  logic                 cfg_penable,
  input  logic                 cfg_pwrite,
  input  logic [5:0]           cfg_paddr,
  input  logic [63:0]          cfg_pwdata,
  output logic [63:0]          cfg_prdata,
  output logic                 cfg_pready
);

  las_pkg::cfg_t      cfg_r;
  las_pkg::dp_cmd_t   cmd;
  las_pkg::dp_status_t status;
  logic [2:0]         reg_idx;
  logic               wr_en;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[5:3];
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        las_pkg::REG_WCL:  cfg_r.wcl        <= cfg_pwdata[47:0];
        las_pkg::REG_WCH:  cfg_r.wch        <= cfg_pwdata[47:0];
        las_pkg::REG_WV:   cfg_r.wv         <= cfg_pwdata[31:0];
        las_pkg::REG_FAM:  cfg_r.fam        <= cfg_pwdata;
        las_pkg::REG_MINN: cfg_r.min_nodes  <= cfg_pwdata[7:0];
        las_pkg::REG_MINW: cfg_r.min_weight <= cfg_pwdata[15:0];
        las_pkg::REG_EXEC: cfg_r.exec_mask  <= cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    unique case (reg_idx)
      las_pkg::REG_WCL:  cfg_prdata = {16'd0, cfg_r.wcl};
      las_pkg::REG_WCH:  cfg_prdata = {16'd0, cfg_r.wch};
      las_pkg::REG_WV:   cfg_prdata = {32'd0, cfg_r.wv};
      las_pkg::REG_FAM:  cfg_prdata = cfg_r.fam;
      las_pkg::REG_MINN: cfg_prdata = {56'd0, cfg_r.min_nodes};
      las_pkg::REG_MINW: cfg_prdata = {48'd0, cfg_r.min_weight};
      las_pkg::REG_EXEC: cfg_prdata = {56'd0, cfg_r.exec_mask};
      default:           cfg_prdata = '0;
    endcase
  end

  las_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_data.command),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .cmd        (cmd)
  );

  las_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cfg      (cfg_r),
    .cmd      (cmd),
    .status   (status),
    .out_data (out_data)
  );

endmodule
